// ===== rtl/core/cvdt_pkg.sv =====
// shared types and constants of the centi value to decimal text block
// used by the front, the queue, the back and the top level; no dependencies
package cvdt_pkg;

   localparam int MAX_CHARS   = 10;
   localparam int COUNT_W     = $clog2(MAX_CHARS + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [1:0] MODE_UNITS  = 2'd0;
   localparam logic [1:0] MODE_TENTHS = 2'd1;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_POINT = 8'h2E;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   // reciprocals for exact division of any 32-bit value
   localparam logic [31:0] RECIP_TEN     = 32'hCCCC_CCCD;
   localparam int          SHIFT_TEN     = 35;
   localparam logic [31:0] RECIP_HUNDRED = 32'h51EB_851F;
   localparam int          SHIFT_HUNDRED = 37;

   typedef struct packed {
      logic [MAX_CHARS-1:0][7:0] chars;
      logic [COUNT_W-1:0]        count;
      logic                      sign;
      logic                      ok;
   } cvdt_text_type;

endpackage

// ===== rtl/core/cvdt_front.sv =====
// front part: accepts items, rounds the magnitude and converts it to digits
// depends on cvdt_pkg; hands a finished text descriptor to the queue
module cvdt_front import cvdt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [47:0]   req_tdata,  // value_centi[31:0], decimal_mode[33:32], capacity[41:34]
   output logic          push_valid,
   input  logic          push_ready,
   output cvdt_text_type push_data
);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_MUL    = 8'b0000_0010,
      ST_REM    = 8'b0000_0100,
      ST_ROUND  = 8'b0000_1000,
      ST_DMUL   = 8'b0001_0000,
      ST_DSPLIT = 8'b0010_0000,
      ST_CHECK  = 8'b0100_0000,
      ST_PUSH   = 8'b1000_0000
   } state_type;

   state_type                 state_ff, state_in;
   logic [31:0]               mag_ff, mag_in;
   logic                      neg_ff, neg_in;
   logic                      tenths_ff, tenths_in;
   logic [7:0]                cap_ff, cap_in;
   logic [63:0]               prod_ff, prod_in;
   logic [27:0]               quot_ff, quot_in;
   logic [6:0]                frac_ff, frac_in;
   logic [27:0]               rem_ff, rem_in;
   logic                      nz_ff, nz_in;
   logic [59:0]               dprod_ff, dprod_in;
   logic [MAX_CHARS-1:0][7:0] chars_ff, chars_in;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic                      ok_ff, ok_in;

   logic [31:0]        raw;
   logic [1:0]         mode;
   logic [7:0]         cap;
   logic [27:0]        quot;
   logic [6:0]         div7;
   logic               inc;
   logic [24:0]        dquot;
   logic [3:0]         digit;
   logic [COUNT_W-1:0] next_count;
   logic               sign;
   logic [COUNT_W-1:0] len;

   assign raw  = req_tdata[31:0];
   assign mode = req_tdata[33:32];
   assign cap  = req_tdata[41:34];

   assign req_tready = (state_ff == ST_IDLE);
   assign push_valid = (state_ff == ST_PUSH);
   assign sign       = neg_ff & nz_ff;

   always_comb begin
      push_data = '0;
      if (ok_ff) begin
         push_data.chars = chars_ff;
         push_data.count = count_ff;
         push_data.sign  = sign;
         push_data.ok    = 1'b1;
      end
   end

   always_comb begin
      state_in  = state_ff;
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      tenths_in = tenths_ff;
      cap_in    = cap_ff;
      prod_in   = prod_ff;
      quot_in   = quot_ff;
      frac_in   = frac_ff;
      rem_in    = rem_ff;
      nz_in     = nz_ff;
      dprod_in  = dprod_ff;
      chars_in  = chars_ff;
      count_in  = count_ff;
      ok_in     = ok_ff;

      quot       = tenths_ff ? prod_ff[SHIFT_TEN +: 28] : 28'(prod_ff[63:SHIFT_HUNDRED]);
      div7       = tenths_ff ? 7'd10 : 7'd100;
      inc        = {frac_ff, 1'b0} >= {1'b0, div7};
      dquot      = dprod_ff[59:SHIFT_TEN];
      digit      = rem_ff[3:0] - 4'(dquot[3:0] * 4'd10);
      next_count = (tenths_ff && count_ff == '0) ? COUNT_W'(2) : count_ff + COUNT_W'(1);
      len        = count_ff + COUNT_W'(sign);

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               neg_in    = raw[31];
               mag_in    = raw[31] ? (32'd0 - raw) : raw;
               tenths_in = (mode == MODE_TENTHS);
               cap_in    = cap;
               count_in  = '0;
               if (cap == 8'd0 || !(mode inside {MODE_UNITS, MODE_TENTHS})) begin
                  ok_in    = 1'b0;
                  state_in = ST_PUSH;
               end else begin
                  ok_in    = 1'b1;
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            prod_in  = 64'(mag_ff) * 64'(tenths_ff ? RECIP_TEN : RECIP_HUNDRED);
            state_in = ST_REM;
         end
         ST_REM: begin
            quot_in  = quot;
            frac_in  = mag_ff[6:0] - 7'(quot[6:0] * div7);
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            rem_in   = quot_ff + 28'(inc);
            nz_in    = (quot_ff != '0) | inc;
            state_in = ST_DMUL;
         end
         ST_DMUL: begin
            dprod_in = 60'(rem_ff) * 60'(RECIP_TEN);
            state_in = ST_DSPLIT;
         end
         ST_DSPLIT: begin
            chars_in[count_ff] = CHAR_ZERO + 8'(digit);
            if (tenths_ff && count_ff == '0) begin
               chars_in[1] = CHAR_POINT;
            end
            count_in = next_count;
            rem_in   = 28'(dquot);
            if (dquot != '0 || (tenths_ff && next_count < COUNT_W'(3))) begin
               state_in = ST_DMUL;
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (8'(len) + 8'd1 > cap_ff) begin
               ok_in = 1'b0;
            end
            state_in = ST_PUSH;
         end
         ST_PUSH: begin
            if (push_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mag_ff    <= mag_in;
      neg_ff    <= neg_in;
      tenths_ff <= tenths_in;
      cap_ff    <= cap_in;
      prod_ff   <= prod_in;
      quot_ff   <= quot_in;
      frac_ff   <= frac_in;
      rem_ff    <= rem_in;
      nz_ff     <= nz_in;
      dprod_ff  <= dprod_in;
      chars_ff  <= chars_in;
      count_ff  <= count_in;
      ok_ff     <= ok_in;
   end

endmodule

// ===== rtl/core/cvdt_queue.sv =====
// short queue of text descriptors between the front and the back
// depends on cvdt_pkg for the descriptor type and the depth
module cvdt_queue import cvdt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  cvdt_text_type push_data,
   output logic          pop_valid,
   input  logic          pop_ready,
   output cvdt_text_type pop_data
);

   cvdt_text_type              entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]       fill_ff, fill_in;
   logic                       do_push;
   logic                       do_pop;

   assign push_ready = (fill_ff != (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   fill_in = fill_ff + 1'b1;
         2'b01:   fill_in = fill_ff - 1'b1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/cvdt_back.sv =====
// back part: emits the characters of one text descriptor, one item per cycle while the result channel is ready
// depends on cvdt_pkg; drives the registered result channel
module cvdt_back import cvdt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          pop_valid,
   output logic          pop_ready,
   input  cvdt_text_type pop_data,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [7:0]    rsp_tdata,  // text_char[7:0]
   output logic          rsp_tuser,  // ok[0]
   output logic          rsp_tlast
);

   logic                      busy_ff, busy_in;
   logic                      sign_ff, sign_in;
   logic                      ok_ff, ok_in;
   logic [COUNT_W-1:0]        idx_ff, idx_in;
   logic [MAX_CHARS-1:0][7:0] chars_ff, chars_in;
   logic                      valid_ff, valid_in;
   logic [7:0]                char_ff, char_in;
   logic                      rok_ff, rok_in;
   logic                      last_ff, last_in;
   logic                      advance;
   logic [COUNT_W-1:0]        idx_dec;

   assign pop_ready  = ~busy_ff;
   assign advance    = ~valid_ff | rsp_tready;
   assign idx_dec    = idx_ff - COUNT_W'(1);
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = char_ff;
   assign rsp_tuser  = rok_ff;
   assign rsp_tlast  = last_ff;

   always_comb begin
      busy_in  = busy_ff;
      sign_in  = sign_ff;
      ok_in    = ok_ff;
      idx_in   = idx_ff;
      chars_in = chars_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      rok_in   = rok_ff;
      last_in  = last_ff;
      if (!busy_ff && pop_valid) begin
         busy_in  = 1'b1;
         sign_in  = pop_data.sign;
         ok_in    = pop_data.ok;
         idx_in   = pop_data.count;
         chars_in = pop_data.chars;
      end
      if (advance) begin
         valid_in = busy_ff;
         if (busy_ff) begin
            if (sign_ff) begin
               char_in = CHAR_MINUS;
               rok_in  = 1'b1;
               last_in = 1'b0;
               sign_in = 1'b0;
            end else if (idx_ff != '0) begin
               char_in = chars_ff[idx_dec];
               rok_in  = 1'b1;
               last_in = 1'b0;
               idx_in  = idx_dec;
            end else begin
               char_in = CHAR_NUL;
               rok_in  = ok_ff;
               last_in = 1'b1;
               busy_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
      sign_ff  <= sign_in;
      ok_ff    <= ok_in;
      idx_ff   <= idx_in;
      chars_ff <= chars_in;
      char_ff  <= char_in;
      rok_ff   <= rok_in;
      last_ff  <= last_in;
   end

endmodule

// ===== rtl/core/centi_value_to_decimal_text.sv =====
// top level of the centi value to decimal text block
// depends on cvdt_pkg, cvdt_front, cvdt_queue and cvdt_back
//
// Each request item carries a signed value in hundredths, a decimals mode and a
// buffer capacity; the block answers with the rounded text, one ASCII character
// per response item, ending in a NUL marked by tlast, or with a single NUL whose
// ok flag is 0 when the mode is invalid, the capacity is zero or the text does
// not fit. The front converts an item with one reciprocal multiply, a remainder
// step and a rounding step, then one reciprocal multiply and one split step per
// digit (1 to 9 digits), a fit check and a push, and takes the next item only
// after it has pushed the last one; an item rejected at the input goes straight
// to the push. The back emits n + 1 items for n characters, one per cycle while
// the result channel is ready, and loads the next text after the NUL. A
// two-entry queue between them lets the front convert the next item while the
// back is still emitting, so the sustained rate is set by the slower of the two.
module centi_value_to_decimal_text import cvdt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // value_centi[31:0], decimal_mode[33:32], capacity[41:34]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // text_char[7:0]
   output logic        rsp_tuser,   // ok[0]
   output logic        rsp_tlast
);

   logic          push_valid;
   logic          push_ready;
   cvdt_text_type push_data;
   logic          pop_valid;
   logic          pop_ready;
   cvdt_text_type pop_data;

   cvdt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   cvdt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   cvdt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
